[src/i2cms_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// I2C master sequencer package
// Beat types, phase codes, control bit masks and status codes shared by the
// sequencer modules and its channel interfaces.
// -----------------------------------------------------------------------------
package i2cms_pkg;

	// Width of the remaining byte counters.
	localparam int COUNT_WIDTH = 16;

	// Transfer phases.
	localparam logic [2:0] PH_START   = 3'd0;
	localparam logic [2:0] PH_ADDR_W  = 3'd1;
	localparam logic [2:0] PH_WRITE   = 3'd2;
	localparam logic [2:0] PH_RESTART = 3'd3;
	localparam logic [2:0] PH_ADDR_R  = 3'd4;
	localparam logic [2:0] PH_READ    = 3'd5;
	localparam logic [2:0] PH_IDLE    = 3'd7;

	// Controller control register bits.
	localparam logic [6:0] CB_AA  = 7'h04;
	localparam logic [6:0] CB_SI  = 7'h08;
	localparam logic [6:0] CB_STO = 7'h10;
	localparam logic [6:0] CB_STA = 7'h20;
	localparam logic [6:0] CB_EN  = 7'h40;

	// Masked controller status codes that the sequencer reacts to.
	localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
	localparam logic [7:0] ST_ADDR_W_NAK  = 8'h20;
	localparam logic [7:0] ST_DATA_W_NAK  = 8'h30;
	localparam logic [7:0] ST_ADDR_R_NAK  = 8'h48;
	localparam logic [7:0] ST_MASK        = 8'hF8;

	// Input actions.
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_EVENT = 1'b1;

	// Result codes.
	localparam logic [1:0] RES_OK  = 2'd0;
	localparam logic [1:0] RES_NAK = 2'd1;
	localparam logic [1:0] RES_ERR = 2'd2;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// One input beat.
	typedef struct packed {
		logic        action;
		logic [6:0]  dev_addr;
		logic [15:0] tx_count;
		logic [15:0] rx_count;
		logic [7:0]  status_code;
		logic [7:0]  tx_byte;
		logic [7:0]  rx_byte;
	} in_item_t;

	// One result beat.
	typedef struct packed {
		logic [6:0] control_set;
		logic [6:0] control_clear;
		logic       data_write;
		logic [7:0] data_value;
		logic       tx_pop;
		logic       rx_push;
		logic       done_res;
		logic [1:0] result_code;
	} out_item_t;

	// Sequencer state carried from one beat to the next.
	typedef struct packed {
		logic [2:0] phase;
		logic [6:0] target_address;
		count_t     write_remaining;
		count_t     read_remaining;
		logic [1:0] last_result;
	} seq_state_t;

endpackage

[src/i2cms_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// I2C master sequencer channels
// Valid/ready channels for the input beats and the result beats.
// -----------------------------------------------------------------------------
interface i2cms_in_if
	import i2cms_pkg::*;
;
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cms_out_if
	import i2cms_pkg::*;
;
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/i2cms_step.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// I2C master sequencer step logic
// Works out the result beat and the next sequencer state from one input beat
// and the current state.
// -----------------------------------------------------------------------------
module i2cms_step
	import i2cms_pkg::*;
(
	input  in_item_t   item,
	input  seq_state_t cur,
	output out_item_t  res,
	output seq_state_t nxt
);

	logic [7:0] status;
	logic [7:0] addr_w;
	count_t     read_dec;
	logic       done;

	assign status = item.status_code & ST_MASK;
	assign addr_w = {cur.target_address, 1'b0};

	// Read counter after taking one byte; it never wraps below zero.
	assign read_dec = (cur.read_remaining != '0) ? cur.read_remaining - count_t'(1) : '0;

	// Phase decode and control outputs.
	always_comb begin
		nxt                   = cur;
		res                   = '0;
		done                  = 1'b0;
		if (item.action == ACT_START) begin
			nxt.target_address  = item.dev_addr;
			nxt.write_remaining = count_t'(item.tx_count);
			nxt.read_remaining  = count_t'(item.rx_count);
			nxt.phase           = PH_START;
			res.control_clear   = CB_STO;
			res.control_set     = CB_EN | CB_STA;
		end else if (status == ST_BUS_ERROR) begin
			nxt.last_result   = RES_ERR;
			res.control_set   = CB_STO;
			nxt.phase         = PH_IDLE;
			done              = 1'b1;
		end else begin
			res.control_clear = CB_SI;
			case (cur.phase)
				PH_START: begin
					nxt.last_result   = RES_OK;
					res.control_clear = CB_SI | CB_STA;
					if (cur.write_remaining != '0) begin
						res.data_write = 1'b1;
						res.data_value = addr_w;
						nxt.phase      = PH_ADDR_W;
					end else if (cur.read_remaining != '0) begin
						res.data_write = 1'b1;
						res.data_value = addr_w | 8'h01;
						nxt.phase      = PH_ADDR_R;
					end else begin
						res.control_set = CB_STO;
						nxt.phase       = PH_IDLE;
						done            = 1'b1;
					end
				end
				PH_ADDR_W: begin
					if (status == ST_ADDR_W_NAK) begin
						res.control_set = CB_STO;
						nxt.phase       = PH_IDLE;
						nxt.last_result = RES_NAK;
						done            = 1'b1;
					end else begin
						res.data_write = 1'b1;
						res.data_value = item.tx_byte;
						res.tx_pop     = 1'b1;
						if (cur.write_remaining != '0) begin
							nxt.write_remaining = cur.write_remaining - count_t'(1);
						end
						nxt.phase = PH_WRITE;
					end
				end
				PH_WRITE: begin
					if (status == ST_DATA_W_NAK) begin
						res.control_set = CB_STO;
						nxt.phase       = PH_IDLE;
						nxt.last_result = RES_NAK;
						done            = 1'b1;
					end else if (cur.write_remaining != '0) begin
						res.data_write      = 1'b1;
						res.data_value      = item.tx_byte;
						res.tx_pop          = 1'b1;
						nxt.write_remaining = cur.write_remaining - count_t'(1);
					end else if (cur.read_remaining != '0) begin
						res.control_set = CB_STA;
						nxt.phase       = PH_RESTART;
					end else begin
						res.control_set = CB_STO;
						nxt.phase       = PH_IDLE;
						done            = 1'b1;
					end
				end
				PH_RESTART: begin
					res.control_clear = CB_SI | CB_STA;
					res.data_write    = 1'b1;
					res.data_value    = addr_w | 8'h01;
					nxt.phase         = PH_ADDR_R;
				end
				PH_ADDR_R: begin
					if (status == ST_ADDR_R_NAK) begin
						res.control_set = CB_STO;
						nxt.phase       = PH_IDLE;
						nxt.last_result = RES_NAK;
						done            = 1'b1;
					end else begin
						if (cur.read_remaining > count_t'(1)) begin
							res.control_set = CB_AA;
						end
						nxt.phase = PH_READ;
					end
				end
				PH_READ: begin
					res.rx_push        = 1'b1;
					nxt.read_remaining = read_dec;
					if (read_dec > count_t'(1)) begin
						res.control_set = CB_AA;
					end else if (read_dec == count_t'(1)) begin
						res.control_clear = CB_SI | CB_AA;
					end else begin
						res.control_set = CB_STO;
						nxt.phase       = PH_IDLE;
						done            = 1'b1;
					end
				end
				default: begin
					// Idle and the unused code: only the interrupt flag is cleared.
					nxt.phase = PH_IDLE;
				end
			endcase
		end
		res.done_res    = done;
		res.result_code = done ? nxt.last_result : RES_OK;
	end

endmodule

[src/i2c_master_transfer_sequencer.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// I2C master write-then-read transfer sequencer
// Tracks a write-then-read transaction and tells the controller driver which
// control bits to change, what to load into the data register and when a
// transfer has ended.
// -----------------------------------------------------------------------------
//
//   channel  role    beat
//   -------  ------  ------------------------------------------------------
//   req      sink    start command or controller status event (in_item_t)
//   rsp      source  control masks, data write, strobes, done (out_item_t)
//
// Every input beat yields exactly one result beat, offered in the cycle after it is taken.
// A beat is accepted in every cycle while the result register is empty or being
// drained, so the sustained rate is one beat per clock; it is set by the single
// output register that separates the two channels.
// The asynchronous reset returns the sequencer to idle with zero counts and a
// success result, and empties the result register.
// -----------------------------------------------------------------------------
module i2c_master_transfer_sequencer
	import i2cms_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	i2cms_in_if.sink    req,
	i2cms_out_if.source rsp
);

	seq_state_t state_q;
	seq_state_t state_nxt;
	out_item_t  res_nxt;
	out_item_t  rsp_data_q;
	logic       rsp_valid_q;
	logic       accept;

	i2cms_step u_step (
		.item (req.data),
		.cur  (state_q),
		.res  (res_nxt),
		.nxt  (state_nxt)
	);

	// Take a beat whenever the result register is free or emptied this cycle.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase           <= PH_IDLE;
			state_q.target_address  <= '0;
			state_q.write_remaining <= '0;
			state_q.read_remaining  <= '0;
			state_q.last_result     <= RES_OK;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_data_q <= res_nxt;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// I2C master transfer sequencer testbench
// Feeds start commands and controller status events into the sequencer and
// compares every result beat, field by field, with an in-bench prediction.
// The stimulus is mostly well-formed write-then-read transfers that end in
// success, a NAK, a bus error or are abandoned, mixed with random noise beats.
// Traffic on both channels runs through phases of idling and stalling.
// -----------------------------------------------------------------------------
module testbench;
	import i2cms_pkg::*;

	// Marks a transfer step at which no NAK code applies.
	localparam logic [7:0] NAK_NONE = 8'hFF;

	typedef enum {FAULT_NONE, FAULT_NAK, FAULT_BUS, FAULT_ABANDON} fault_t;
	typedef enum logic [1:0] {
		MODE_FREE, MODE_SENDER_IDLE, MODE_RECEIVER_STALL, MODE_BOTH
	} traffic_t;

	logic clk = 1'b0;
	logic arst_n;

	i2cms_in_if  req_ch ();
	i2cms_out_if rsp_ch ();

	i2c_master_transfer_sequencer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	in_item_t   pending_beats[$];
	out_item_t  expected_results[$];
	seq_state_t xfer;
	int         beats_issued = 0;
	int         mismatch_count = 0;
	int         hold_left;
	bit         hold_started;
	traffic_t   traffic_mode;

	assign traffic_mode = traffic_t'(2'(beats_issued / 150));

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Works out the result of one accepted beat and advances the transfer state.
	function automatic out_item_t sequence_beat(in_item_t b);
		out_item_t  r;
		logic [7:0] st;
		logic [7:0] sla;
		r = '0;
		st = b.status_code & ST_MASK;
		sla = {xfer.target_address, 1'b0};
		if (b.action == ACT_START) begin
			xfer.target_address = b.dev_addr;
			xfer.write_remaining = b.tx_count;
			xfer.read_remaining = b.rx_count;
			xfer.phase = PH_START;
			r.control_clear = CB_STO;
			r.control_set = CB_EN | CB_STA;
		end else if (st == ST_BUS_ERROR) begin
			xfer.last_result = RES_ERR;
			xfer.phase = PH_IDLE;
			r.control_set = CB_STO;
			r.done_res = 1'b1;
		end else begin
			r.control_clear = CB_SI;
			case (xfer.phase)
				PH_START: begin
					xfer.last_result = RES_OK;
					r.control_clear |= CB_STA;
					if (xfer.write_remaining != 0) begin
						r.data_write = 1'b1;
						r.data_value = sla;
						xfer.phase = PH_ADDR_W;
					end else if (xfer.read_remaining != 0) begin
						r.data_write = 1'b1;
						r.data_value = sla | 8'h01;
						xfer.phase = PH_ADDR_R;
					end else begin
						r.control_set = CB_STO;
						r.done_res = 1'b1;
						xfer.phase = PH_IDLE;
					end
				end
				PH_ADDR_W: begin
					if (st == ST_ADDR_W_NAK) begin
						r.control_set = CB_STO;
						r.done_res = 1'b1;
						xfer.last_result = RES_NAK;
						xfer.phase = PH_IDLE;
					end else begin
						r.data_write = 1'b1;
						r.data_value = b.tx_byte;
						r.tx_pop = 1'b1;
						if (xfer.write_remaining != 0)
							xfer.write_remaining--;
						xfer.phase = PH_WRITE;
					end
				end
				PH_WRITE: begin
					if (st == ST_DATA_W_NAK) begin
						r.control_set = CB_STO;
						r.done_res = 1'b1;
						xfer.last_result = RES_NAK;
						xfer.phase = PH_IDLE;
					end else if (xfer.write_remaining != 0) begin
						r.data_write = 1'b1;
						r.data_value = b.tx_byte;
						r.tx_pop = 1'b1;
						xfer.write_remaining--;
					end else if (xfer.read_remaining != 0) begin
						r.control_set = CB_STA;
						xfer.phase = PH_RESTART;
					end else begin
						r.control_set = CB_STO;
						r.done_res = 1'b1;
						xfer.phase = PH_IDLE;
					end
				end
				PH_RESTART: begin
					r.control_clear |= CB_STA;
					r.data_write = 1'b1;
					r.data_value = sla | 8'h01;
					xfer.phase = PH_ADDR_R;
				end
				PH_ADDR_R: begin
					if (st == ST_ADDR_R_NAK) begin
						r.control_set = CB_STO;
						r.done_res = 1'b1;
						xfer.last_result = RES_NAK;
						xfer.phase = PH_IDLE;
					end else begin
						if (xfer.read_remaining > 1)
							r.control_set = CB_AA;
						xfer.phase = PH_READ;
					end
				end
				PH_READ: begin
					r.rx_push = 1'b1;
					if (xfer.read_remaining != 0)
						xfer.read_remaining--;
					if (xfer.read_remaining > 1) begin
						r.control_set = CB_AA;
					end else if (xfer.read_remaining == 1) begin
						r.control_clear |= CB_AA;
					end else begin
						r.control_set = CB_STO;
						r.done_res = 1'b1;
						xfer.phase = PH_IDLE;
					end
				end
				default: begin
					xfer.phase = PH_IDLE;
				end
			endcase
		end
		if (r.done_res)
			r.result_code = xfer.last_result;
		return r;
	endfunction

	function automatic bit draw(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic in_item_t random_beat();
		return in_item_t'({$urandom, $urandom});
	endfunction

	function automatic in_item_t make_start(logic [6:0] addr, logic [15:0] wn, logic [15:0] rn);
		in_item_t b;
		b = random_beat();
		b.action = ACT_START;
		b.dev_addr = addr;
		b.tx_count = wn;
		b.rx_count = rn;
		return b;
	endfunction

	function automatic in_item_t make_event(logic [7:0] status);
		in_item_t b;
		b = random_beat();
		b.action = ACT_EVENT;
		b.status_code = status;
		return b;
	endfunction

	// A status that is neither a bus error nor the NAK code of the current step.
	function automatic logic [7:0] random_status(logic [7:0] nak);
		logic [7:0] s;
		do
			s = 8'($urandom);
		while ((s & ST_MASK) == ST_BUS_ERROR || (s & ST_MASK) == nak);
		return s;
	endfunction

	// Queues a start beat and the status events of a whole transfer, optionally
	// broken off by a NAK, a bus error or an early abandon.
	task automatic append_transfer(logic [6:0] addr, int wn, int rn, fault_t fault);
		logic [7:0] nak_code[$];
		int         cand[$];
		int         cut;
		int         fault_at;
		logic [7:0] fault_status;
		nak_code.push_back(NAK_NONE);
		if (wn > 0) begin
			nak_code.push_back(ST_ADDR_W_NAK);
			repeat (wn) nak_code.push_back(ST_DATA_W_NAK);
		end
		if (rn > 0) begin
			if (wn > 0)
				nak_code.push_back(NAK_NONE);
			nak_code.push_back(ST_ADDR_R_NAK);
			repeat (rn) nak_code.push_back(NAK_NONE);
		end
		cut = nak_code.size();
		fault_at = -1;
		fault_status = '0;
		case (fault)
			FAULT_NAK: begin
				foreach (nak_code[i])
					if (nak_code[i] != NAK_NONE)
						cand.push_back(i);
				if (cand.size() > 0) begin
					fault_at = cand[$urandom_range(cand.size() - 1)];
					fault_status = nak_code[fault_at] | 8'($urandom_range(7));
					cut = fault_at + 1;
				end
			end
			FAULT_BUS: begin
				fault_at = $urandom_range(cut - 1);
				fault_status = 8'($urandom_range(7));
				cut = fault_at + 1;
			end
			FAULT_ABANDON: begin
				cut = $urandom_range(cut - 1);
			end
			default: begin
			end
		endcase
		pending_beats.push_back(make_start(addr, 16'(wn), 16'(rn)));
		for (int k = 0; k < cut; k++)
			pending_beats.push_back(make_event(k == fault_at ? fault_status
				: random_status(nak_code[k])));
	endtask

	task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_result(out_item_t got);
		out_item_t want;
		if (expected_results.size() == 0) begin
			$error("Result beat arrived with nothing expected");
			mismatch_count++;
		end else begin
			want = expected_results.pop_front();
			compare_field("control_set", 8'(want.control_set), 8'(got.control_set));
			compare_field("control_clear", 8'(want.control_clear), 8'(got.control_clear));
			compare_field("data_write", 8'(want.data_write), 8'(got.data_write));
			compare_field("data_value", want.data_value, got.data_value);
			compare_field("tx_pop", 8'(want.tx_pop), 8'(got.tx_pop));
			compare_field("rx_push", 8'(want.rx_push), 8'(got.rx_push));
			compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
			compare_field("result_code", 8'(want.result_code), 8'(got.result_code));
		end
	endtask

	// Driver: predicts each accepted beat and offers the next pending one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				expected_results.push_back(sequence_beat(req_ch.data));
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_beats.size() > 0
						&& !(traffic_mode == MODE_SENDER_IDLE && draw(84))
						&& !(traffic_mode == MODE_BOTH && draw(12))) begin
					req_ch.valid <= 1'b1;
					req_ch.data <= pending_beats.pop_front();
					beats_issued++;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off while the sender keeps offering, so that the
	// result register fills and the input channel stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_started <= 1'b0;
		end else if (!hold_started && beats_issued >= 620) begin
			hold_left <= 80;
			hold_started <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: checks each accepted result beat and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready)
				check_result(rsp_ch.data);
			rsp_ch.ready <= hold_left == 0
				&& !(traffic_mode == MODE_RECEIVER_STALL && draw(84))
				&& !(traffic_mode == MODE_BOTH && draw(12));
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int     pick;
		int     wn;
		int     rn;
		fault_t fault;
		arst_n = 1'b0;
		xfer = '0;
		xfer.phase = PH_IDLE;
		xfer.last_result = RES_OK;

		// Events while idle: a plain status only clears SI, a bus error ends.
		pending_beats.push_back(make_event(8'h08));
		pending_beats.push_back(make_event(8'h07));
		// Empty transfer to the highest address.
		pending_beats.push_back(make_start(7'h7F, 16'd0, 16'd0));
		pending_beats.push_back(make_event(8'h08));
		// One byte written, three read, so AA is set and then cleared.
		pending_beats.push_back(make_start(7'h00, 16'd1, 16'd3));
		pending_beats.push_back(make_event(8'h08));
		pending_beats.push_back(make_event(8'h18));
		pending_beats.push_back(make_event(8'h28));
		pending_beats.push_back(make_event(8'h10));
		pending_beats.push_back(make_event(8'hFF));
		pending_beats.push_back(make_event(8'h50));
		pending_beats.push_back(make_event(8'h50));
		pending_beats.push_back(make_event(8'h58));
		// Address NAK on the write.
		pending_beats.push_back(make_start(7'h55, 16'd1, 16'd0));
		pending_beats.push_back(make_event(8'h08));
		pending_beats.push_back(make_event(8'h20));
		// Data NAK part way through the write.
		pending_beats.push_back(make_start(7'h2A, 16'd2, 16'd5));
		pending_beats.push_back(make_event(8'h08));
		pending_beats.push_back(make_event(8'h18));
		pending_beats.push_back(make_event(8'h30));
		// Address NAK on the read, with low status bits that are masked off.
		pending_beats.push_back(make_start(7'h11, 16'd0, 16'd1));
		pending_beats.push_back(make_event(8'h08));
		pending_beats.push_back(make_event(8'h4F));
		// Largest counts, cut short by a bus error.
		pending_beats.push_back(make_start(7'h3C, 16'hFFFF, 16'hFFFF));
		pending_beats.push_back(make_event(8'h08));
		pending_beats.push_back(make_event(8'h00));

		// Random part: mostly whole transfers, some noise and large counts.
		while (pending_beats.size() < 1050) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				repeat ($urandom_range(1, 3)) pending_beats.push_back(random_beat());
			end else if (pick < 14) begin
				pending_beats.push_back(make_start(7'($urandom), 16'($urandom),
					16'($urandom)));
				repeat ($urandom_range(4))
					pending_beats.push_back(make_event(random_status(NAK_NONE)));
			end else begin
				wn = draw(10) ? $urandom_range(24) : $urandom_range(4);
				rn = draw(10) ? $urandom_range(24) : $urandom_range(4);
				pick = $urandom_range(99);
				fault = pick < 60 ? FAULT_NONE : pick < 75 ? FAULT_NAK
					: pick < 87 ? FAULT_BUS : FAULT_ABANDON;
				append_transfer(7'($urandom), wn, rn, fault);
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_beats.size() != 0 || req_ch.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(300000 * 12);
		$display("Mismatches found");
		$finish;
	end

endmodule
